[design/pwbd_pkg.sv]
// Package for the pulse-wave beat detector: widths, reset values, register codes
// and the sequencer state type. It depends on nothing else.
`default_nettype none

package pwbd_pkg;

    localparam int TIME_W      = 14;
    localparam int PERIOD_W    = 7;
    localparam int REFR_W      = 11;
    localparam int BPM_W       = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int USER_W      = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = 14'h3FFF;
    localparam logic [BPM_W-1:0]  BPM_MAX  = 12'hFFF;
    localparam int BPM_NUMERATOR = 60000;

    // x / 5 == (x * 13108) >> 16 for every x below 16384
    localparam int RECIP_W    = 15;
    localparam int DIV5_RECIP = 13108;
    localparam int DIV5_SHIFT = 16;

    localparam int PERIOD_RST        = 10;
    localparam int REFR_RST          = 250;
    localparam int TIMEOUT_RST       = 2500;
    localparam int RESTART_LEVEL_RST = 512;
    localparam int INTERVAL_RST      = 600;
    localparam int NOTCH_RST         = 360;
    localparam int AMPLITUDE_RST     = 100;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFRACTORY    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESTART_LEVEL = 3'd3;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_EVAL     = 5'b00010,
        ST_DIV_MEAN = 5'b00100,
        ST_DIV_BPM  = 5'b01000,
        ST_DONE     = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[design/pulse_wave_beat_detector.sv]
// An accepted sample passes ST_EVAL and ST_DONE; one that yields a new BPM also passes
// ST_DIV_MEAN and ST_DIV_BPM (two bit-serial divisions of 18 steps each on one shared
// divider). Samples are taken only in ST_IDLE, after the last result is loaded; a stalled
// result holds the sequencer in its last state. Reset (rst_n low, asynchronous)
// loads the register defaults and the restart state; the interval history has no reset.
`default_nettype none

module pulse_wave_beat_detector #(
    parameter int HISTORY_DEPTH = 10,
    parameter int SAMPLE_BITS   = 10,
    localparam int IN_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_FIELDS_W = pwbd_pkg::BPM_W + pwbd_pkg::TIME_W + SAMPLE_BITS,
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pwbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pwbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]            s_axis_tdata,  // sample
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                m_axis_tdata,  // bpm, interval_ms, amplitude
    output logic [pwbd_pkg::USER_W-1:0]           m_axis_tuser   // pulse, beat
);

    localparam int TW      = pwbd_pkg::TIME_W;
    localparam int SB      = SAMPLE_BITS;
    localparam int TOTAL_W = TW + $clog2(HISTORY_DEPTH);
    localparam int DIV_W   = (TOTAL_W > 16) ? TOTAL_W : 16;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int PROD_W  = TW + pwbd_pkg::RECIP_W;

    pwbd_pkg::state_t state_reg, state_next;

    logic [pwbd_pkg::PERIOD_W-1:0] period_reg;
    logic [pwbd_pkg::REFR_W-1:0]   refr_reg;
    logic [TW-1:0]                 timeout_reg;
    logic [SB-1:0]                 restart_reg;

    logic [TW-1:0]              since_reg, since_next;
    logic [TW-1:0]              interval_reg, interval_next;
    logic [TW-1:0]              notch_reg, notch_next;
    logic [SB-1:0]              peak_reg, peak_next;
    logic [SB-1:0]              trough_reg, trough_next;
    logic [SB-1:0]              thr_reg, thr_next;
    logic                       pulse_reg, pulse_next;
    logic                       first_reg, first_next;
    logic                       second_reg, second_next;
    logic [pwbd_pkg::BPM_W-1:0] bpm_reg, bpm_next;
    logic [SB-1:0]              amp_reg, amp_next;
    logic                       beat_reg, beat_next;
    logic                       out_valid_reg;

    logic [SB-1:0]      sample_reg;
    logic [TW-1:0]      hist_reg [HISTORY_DEPTH];
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [DIV_W-1:0]   quo_reg;
    logic [TW-1:0]      rem_reg;
    logic [TW-1:0]      den_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [TW:0]           time_sum;
    logic [TW-1:0]         now_ms;
    logic                  hit;
    logic                  hist_fill;
    logic [SB:0]           thr_sum;
    logic [PROD_W-1:0]     div5_prod;
    logic [TW-1:0]         div5_q;
    logic [TW:0]           rem_shift;
    logic [TW+1:0]         trial;
    logic                  q_bit;
    logic [TW-1:0]         rem_step;
    logic [DIV_W-1:0]      quo_step;
    logic                  out_load;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == pwbd_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

    assign time_sum = {1'b0, since_reg} + (TW + 1)'(period_reg);
    assign now_ms   = time_sum[TW] ? pwbd_pkg::TIME_MAX : time_sum[TW-1:0];

    assign div5_prod  = PROD_W'(interval_reg) * PROD_W'(pwbd_pkg::DIV5_RECIP);
    assign div5_q     = TW'(div5_prod[PROD_W-1:pwbd_pkg::DIV5_SHIFT]);
    assign notch_next = TW'({div5_q, 1'b0} + {1'b0, div5_q});

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, den_reg};
    assign q_bit     = ~trial[TW+1];
    assign rem_step  = q_bit ? trial[TW-1:0] : rem_shift[TW-1:0];
    assign quo_step  = {quo_reg[DIV_W-2:0], q_bit};

    assign out_load = (state_reg == pwbd_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        since_next    = now_ms;
        interval_next = interval_reg;
        peak_next     = peak_reg;
        trough_next   = trough_reg;
        thr_next      = thr_reg;
        pulse_next    = pulse_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        amp_next      = amp_reg;
        beat_next     = 1'b0;
        hist_fill     = 1'b0;
        thr_sum       = '0;
        hit = (now_ms > TW'(refr_reg)) && (sample_reg > thr_reg) && !pulse_reg
              && (now_ms > notch_reg);

        if ((sample_reg < thr_reg) && (now_ms > notch_reg) && (sample_reg < trough_reg))
        begin
            trough_next = sample_reg;
        end
        if ((sample_reg > thr_reg) && (sample_reg > peak_reg))
        begin
            peak_next = sample_reg;
        end

        if (hit)
        begin
            pulse_next    = 1'b1;
            interval_next = now_ms;
            since_next    = '0;
            if (first_reg)
            begin
                first_next = 1'b0;
            end
            else
            begin
                second_next = 1'b0;
                hist_fill   = second_reg;
                beat_next   = 1'b1;
            end
        end

        if (!(hit && first_reg))
        begin
            if ((sample_reg < thr_reg) && pulse_next)
            begin
                pulse_next  = 1'b0;
                amp_next    = (peak_next >= trough_next) ? (peak_next - trough_next) : '0;
                thr_sum     = (SB + 1)'(amp_next >> 1) + (SB + 1)'(trough_next);
                thr_next    = thr_sum[SB-1:0];
                peak_next   = thr_sum[SB-1:0];
                trough_next = thr_sum[SB-1:0];
            end
            if (now_ms > timeout_reg)
            begin
                thr_next    = restart_reg;
                peak_next   = restart_reg;
                trough_next = restart_reg;
                since_next  = '0;
                first_next  = 1'b1;
                second_next = 1'b1;
            end
        end

        if (hist_fill)
        begin
            total_next = TOTAL_W'(now_ms) * TOTAL_W'(HISTORY_DEPTH);
        end
        else
        begin
            total_next = total_reg - TOTAL_W'(hist_reg[0]) + TOTAL_W'(now_ms);
        end

        if (|quo_step[DIV_W-1:pwbd_pkg::BPM_W])
        begin
            bpm_next = pwbd_pkg::BPM_MAX;
        end
        else
        begin
            bpm_next = quo_step[pwbd_pkg::BPM_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pwbd_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = pwbd_pkg::ST_EVAL;
                end
            end
            pwbd_pkg::ST_EVAL:
            begin
                state_next = beat_next ? pwbd_pkg::ST_DIV_MEAN : pwbd_pkg::ST_DONE;
            end
            pwbd_pkg::ST_DIV_MEAN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = pwbd_pkg::ST_DIV_BPM;
                end
            end
            pwbd_pkg::ST_DIV_BPM:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = pwbd_pkg::ST_DONE;
                end
            end
            pwbd_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = pwbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwbd_pkg::ST_IDLE;
            period_reg    <= pwbd_pkg::PERIOD_W'(pwbd_pkg::PERIOD_RST);
            refr_reg      <= pwbd_pkg::REFR_W'(pwbd_pkg::REFR_RST);
            timeout_reg   <= TW'(pwbd_pkg::TIMEOUT_RST);
            restart_reg   <= SB'(pwbd_pkg::RESTART_LEVEL_RST);
            since_reg     <= '0;
            interval_reg  <= TW'(pwbd_pkg::INTERVAL_RST);
            notch_reg     <= TW'(pwbd_pkg::NOTCH_RST);
            peak_reg      <= SB'(pwbd_pkg::RESTART_LEVEL_RST);
            trough_reg    <= SB'(pwbd_pkg::RESTART_LEVEL_RST);
            thr_reg       <= SB'(pwbd_pkg::RESTART_LEVEL_RST);
            pulse_reg     <= 1'b0;
            first_reg     <= 1'b1;
            second_reg    <= 1'b1;
            bpm_reg       <= '0;
            amp_reg       <= SB'(pwbd_pkg::AMPLITUDE_RST);
            beat_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            notch_reg <= notch_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pwbd_pkg::CFG_SAMPLE_PERIOD: period_reg  <= cfg_data[pwbd_pkg::PERIOD_W-1:0];
                    pwbd_pkg::CFG_REFRACTORY:    refr_reg    <= cfg_data[pwbd_pkg::REFR_W-1:0];
                    pwbd_pkg::CFG_TIMEOUT:       timeout_reg <= cfg_data[TW-1:0];
                    pwbd_pkg::CFG_RESTART_LEVEL: restart_reg <= cfg_data[SB-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == pwbd_pkg::ST_EVAL)
            begin
                since_reg    <= since_next;
                interval_reg <= interval_next;
                peak_reg     <= peak_next;
                trough_reg   <= trough_next;
                thr_reg      <= thr_next;
                pulse_reg    <= pulse_next;
                first_reg    <= first_next;
                second_reg   <= second_next;
                amp_reg      <= amp_next;
                beat_reg     <= beat_next;
            end

            if ((state_reg == pwbd_pkg::ST_DIV_BPM) && (cnt_reg == '0))
            begin
                bpm_reg <= bpm_next;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sample_reg <= s_axis_tdata[SB-1:0];
        end

        if ((state_reg == pwbd_pkg::ST_EVAL) && beat_next)
        begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
            begin
                hist_reg[i] <= hist_fill ? now_ms : hist_reg[i+1];
            end
            hist_reg[HISTORY_DEPTH-1] <= now_ms;
            total_reg <= total_next;
            quo_reg   <= DIV_W'(total_next);
            den_reg   <= TW'(HISTORY_DEPTH);
            rem_reg   <= '0;
            cnt_reg   <= CNT_W'(DIV_W - 1);
        end
        else if (state_reg == pwbd_pkg::ST_DIV_MEAN)
        begin
            if (cnt_reg == '0)
            begin
                quo_reg <= DIV_W'(pwbd_pkg::BPM_NUMERATOR);
                den_reg <= quo_step[TW-1:0];
                rem_reg <= '0;
                cnt_reg <= CNT_W'(DIV_W - 1);
            end
            else
            begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
        else if (state_reg == pwbd_pkg::ST_DIV_BPM)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end

        if (out_load)
        begin
            m_axis_tdata <= OUT_TDATA_W'({amp_reg, interval_reg, bpm_reg});
            m_axis_tuser <= {beat_reg, pulse_reg};
        end
    end

endmodule

`default_nettype wire

[design/pwbd_checker.sv]
// Port-level checker for the pulse-wave beat detector and its bind to the top level.
// Depends on pwbd_pkg for field widths.
`default_nettype none

module pwbd_checker #(
    parameter int TDATA_W = 40
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [TDATA_W-1:0]            m_axis_tdata,
    input wire logic [pwbd_pkg::USER_W-1:0]   m_axis_tuser
);

    localparam int BW = pwbd_pkg::BPM_W;
    localparam int TW = pwbd_pkg::TIME_W;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // take one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while busy");

    // a beat starts a pulse
    a_beat_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("beat without pulse");

    // a beat carries a nonzero rate and interval
    a_beat_vals: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
        (m_axis_tdata[BW-1:0] != '0) && (m_axis_tdata[BW+TW-1:BW] != '0))
        else $error("beat with zero bpm or interval");

endmodule

bind pulse_wave_beat_detector pwbd_checker #(
    .TDATA_W (OUT_TDATA_W)
) u_pwbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
